@@ sv/mvp_pkg.sv @@
// Shared types, constants and opcodes for the mirror vertex pairing block.
`default_nettype none

package mvp_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int COORD_WIDTH  = 24;

    localparam int POS_W   = 24;
    localparam int QIDX_W  = 10;
    localparam int TOL_W   = 23;
    localparam int IDX_W   = $clog2(MAX_VERTICES);
    localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
    localparam int QCMP_W  = (QIDX_W > CNT_W) ? QIDX_W : CNT_W;
    localparam int PX_W    = COORD_WIDTH + 1;
    localparam int DX_W    = COORD_WIDTH + 2;
    localparam int ABS_W   = COORD_WIDTH + 1;
    localparam int CMP_W   = (ABS_W > TOL_W) ? ABS_W : TOL_W;
    localparam int SQ_IN_W = (ABS_W < TOL_W) ? ABS_W : TOL_W;
    localparam int SQ_W    = 2 * SQ_IN_W;
    localparam int SUM_W   = 2 * TOL_W + 2;
    localparam int VTX_W   = 3 * COORD_WIDTH;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(256);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [QIDX_W-1:0]       query_index;
    } in_item_t;

    typedef struct packed {
        logic              partner_found;
        logic [QIDX_W-1:0] partner_index;
        logic              query_error;
    } out_item_t;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] tag;
    } dist_ctl_t;

    typedef struct packed {
        logic             busy;
        logic             hit;
        logic [IDX_W-1:0] tag;
        logic [SUM_W-1:0] sum;
    } dist_res_t;

endpackage

`default_nettype wire

@@ sv/mirror_vertex_pairing.sv @@
// Top level: vertex store, scan sequencer and result register.
//
//  channel  | ports                  | payload
//  ---------+------------------------+-------------------------
//  input    | s_valid, s_ready       | s_item (mvp_pkg::in_item_t)
//  result   | m_valid, m_ready       | m_item (mvp_pkg::out_item_t)
//  config   | cfg_valid, cfg_ready   | cfg_data (tolerance)
//
// Clear and append complete in IDLE. A query holds the input through accept, setup,
// one store read per vertex, the registered read and the three-stage distance pipeline,
// the drain wait and the result load.
// An out-of-range query goes from accept straight to the result load.
// Reset is synchronous; the store is not cleared, only the vertex count.
// s_ready is low from query accept until the result is loaded into m_item.
`default_nettype none

module mirror_vertex_pairing (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire mvp_pkg::in_item_t           s_item,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output mvp_pkg::out_item_t               m_item,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [mvp_pkg::TOL_W-1:0]   cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_QWAIT = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam int CW = mvp_pkg::COORD_WIDTH;

    logic [2:0]                  state_reg, state_next;
    logic [mvp_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [mvp_pkg::TOL_W-1:0]   tol_reg;
    logic [mvp_pkg::IDX_W-1:0]   scan_reg, scan_next;
    logic                        rd_vld_reg, rd_vld_next;
    logic [mvp_pkg::IDX_W-1:0]   rd_tag_reg, rd_tag_next;
    logic                        m_valid_reg, m_valid_next;
    mvp_pkg::out_item_t          m_item_reg, m_item_next;

    logic signed [mvp_pkg::PX_W-1:0] px_reg, px_next;
    logic signed [CW-1:0]            py_reg, py_next, pz_reg, pz_next;
    logic [mvp_pkg::SUM_W-1:0]       best_d_reg, best_d_next;
    logic [mvp_pkg::IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic                            found_reg, found_next;
    logic                            err_reg, err_next;

    logic                        wr_en, rd_en;
    logic [mvp_pkg::IDX_W-1:0]   rd_addr;
    logic [mvp_pkg::VTX_W-1:0]   wr_data, rd_data;
    logic signed [CW-1:0]        rd_x, rd_y, rd_z;
    logic                        accept;

    mvp_pkg::dist_ctl_t          dctl;
    mvp_pkg::dist_res_t          dres;

    assign rd_x = rd_data[3*CW-1:2*CW];
    assign rd_y = rd_data[2*CW-1:CW];
    assign rd_z = rd_data[CW-1:0];
    assign wr_data = {CW'(s_item.pos_x), CW'(s_item.pos_y), CW'(s_item.pos_z)};

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    assign dctl.vld = rd_vld_reg;
    assign dctl.tag = rd_tag_reg;

    mvp_ram #(
        .WIDTH(mvp_pkg::VTX_W),
        .DEPTH(mvp_pkg::MAX_VERTICES)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(count_reg[mvp_pkg::IDX_W-1:0]),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    mvp_dist_unit u_dist (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (dctl),
        .px     (px_reg),
        .py     (py_reg),
        .pz     (pz_reg),
        .vx     (rd_x),
        .vy     (rd_y),
        .vz     (rd_z),
        .tol    (tol_reg),
        .res    (dres)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        rd_vld_next   = 1'b0;
        rd_tag_next   = scan_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_item_next   = m_item_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        pz_next       = pz_reg;
        best_d_next   = best_d_reg;
        best_idx_next = best_idx_reg;
        found_next    = found_reg;
        err_next      = err_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = scan_reg;

        if (dres.hit && (dres.sum < best_d_reg)) begin
            best_d_next   = dres.sum;
            best_idx_next = dres.tag;
            found_next    = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_item.op)
                        mvp_pkg::OP_CLEAR: begin
                            count_next = '0;
                        end
                        mvp_pkg::OP_APPEND: begin
                            if (count_reg < mvp_pkg::CNT_W'(mvp_pkg::MAX_VERTICES)) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + mvp_pkg::CNT_W'(1);
                            end
                        end
                        mvp_pkg::OP_QUERY: begin
                            if (mvp_pkg::QCMP_W'(s_item.query_index)
                                    >= mvp_pkg::QCMP_W'(count_reg)) begin
                                found_next    = 1'b0;
                                best_idx_next = '0;
                                err_next      = 1'b1;
                                state_next    = ST_DONE;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = mvp_pkg::IDX_W'(s_item.query_index);
                                state_next = ST_QWAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_QWAIT: begin
                px_next       = -mvp_pkg::PX_W'(rd_x);
                py_next       = rd_y;
                pz_next       = rd_z;
                best_d_next   = mvp_pkg::SUM_W'(tol_reg) * mvp_pkg::SUM_W'(tol_reg);
                best_idx_next = '0;
                found_next    = 1'b0;
                err_next      = 1'b0;
                scan_next     = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                rd_en       = 1'b1;
                rd_vld_next = 1'b1;
                if (mvp_pkg::CNT_W'(scan_reg) == count_reg - mvp_pkg::CNT_W'(1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_next = scan_reg + mvp_pkg::IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !dres.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_item_next.partner_found = found_reg;
                    m_item_next.partner_index = found_reg ?
                                                mvp_pkg::QIDX_W'(best_idx_reg) : '0;
                    m_item_next.query_error   = err_reg;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            tol_reg     <= mvp_pkg::TOL_RESET;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                tol_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg     <= scan_next;
        rd_tag_reg   <= rd_tag_next;
        m_item_reg   <= m_item_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        pz_reg       <= pz_next;
        best_d_reg   <= best_d_next;
        best_idx_reg <= best_idx_next;
        found_reg    <= found_next;
        err_reg      <= err_next;
    end

endmodule

`default_nettype wire

@@ sv/mvp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mvp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/mvp_dist_unit.sv @@
// Pipelined squared-distance unit shared by every vertex of a scan.
`default_nettype none

module mvp_dist_unit (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire mvp_pkg::dist_ctl_t                     ctl,
    input  wire logic signed [mvp_pkg::PX_W-1:0]        px,
    input  wire logic signed [mvp_pkg::COORD_WIDTH-1:0] py,
    input  wire logic signed [mvp_pkg::COORD_WIDTH-1:0] pz,
    input  wire logic signed [mvp_pkg::COORD_WIDTH-1:0] vx,
    input  wire logic signed [mvp_pkg::COORD_WIDTH-1:0] vy,
    input  wire logic signed [mvp_pkg::COORD_WIDTH-1:0] vz,
    input  wire logic [mvp_pkg::TOL_W-1:0]              tol,
    output mvp_pkg::dist_res_t                          res
);

    logic signed [mvp_pkg::DX_W-1:0] dx, dy, dz;
    logic [mvp_pkg::DX_W-1:0]        mx, my, mz;

    logic                         a_vld_reg;
    logic [mvp_pkg::IDX_W-1:0]    a_tag_reg;
    logic [mvp_pkg::ABS_W-1:0]    ax_reg, ay_reg, az_reg;

    logic                         b_vld_reg, b_rng_reg;
    logic [mvp_pkg::IDX_W-1:0]    b_tag_reg;
    logic [mvp_pkg::SQ_W-1:0]     sqx_reg, sqy_reg, sqz_reg;

    logic                         c_vld_reg, c_hit_reg;
    logic [mvp_pkg::IDX_W-1:0]    c_tag_reg;
    logic [mvp_pkg::SUM_W-1:0]    sum_reg;

    logic [mvp_pkg::CMP_W-1:0]    tol_c;
    logic                         rng;
    logic [mvp_pkg::SQ_IN_W-1:0]  sx, sy, sz;

    assign dx = mvp_pkg::DX_W'(px) - mvp_pkg::DX_W'(vx);
    assign dy = mvp_pkg::DX_W'(py) - mvp_pkg::DX_W'(vy);
    assign dz = mvp_pkg::DX_W'(pz) - mvp_pkg::DX_W'(vz);
    assign mx = dx[mvp_pkg::DX_W-1] ? -dx : dx;
    assign my = dy[mvp_pkg::DX_W-1] ? -dy : dy;
    assign mz = dz[mvp_pkg::DX_W-1] ? -dz : dz;

    // a component at or beyond the radius cannot be inside
    assign tol_c = mvp_pkg::CMP_W'(tol);
    assign rng = (mvp_pkg::CMP_W'(ax_reg) < tol_c) && (mvp_pkg::CMP_W'(ay_reg) < tol_c)
              && (mvp_pkg::CMP_W'(az_reg) < tol_c);
    assign sx = ax_reg[mvp_pkg::SQ_IN_W-1:0];
    assign sy = ay_reg[mvp_pkg::SQ_IN_W-1:0];
    assign sz = az_reg[mvp_pkg::SQ_IN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= ctl.vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_tag_reg <= ctl.tag;
        ax_reg    <= mx[mvp_pkg::ABS_W-1:0];
        ay_reg    <= my[mvp_pkg::ABS_W-1:0];
        az_reg    <= mz[mvp_pkg::ABS_W-1:0];

        b_tag_reg <= a_tag_reg;
        b_rng_reg <= rng;
        sqx_reg   <= mvp_pkg::SQ_W'(sx) * mvp_pkg::SQ_W'(sx);
        sqy_reg   <= mvp_pkg::SQ_W'(sy) * mvp_pkg::SQ_W'(sy);
        sqz_reg   <= mvp_pkg::SQ_W'(sz) * mvp_pkg::SQ_W'(sz);

        c_tag_reg <= b_tag_reg;
        c_hit_reg <= b_vld_reg && b_rng_reg;
        sum_reg   <= mvp_pkg::SUM_W'(sqx_reg) + mvp_pkg::SUM_W'(sqy_reg)
                   + mvp_pkg::SUM_W'(sqz_reg);
    end

    assign res.busy = a_vld_reg || b_vld_reg || c_vld_reg;
    assign res.hit  = c_vld_reg && c_hit_reg;
    assign res.tag  = c_tag_reg;
    assign res.sum  = sum_reg;

endmodule

`default_nettype wire

@@ sv/mvp_checker.sv @@
// Port-level assertions for the mirror vertex pairing top level, with bind.
`default_nettype none

module mvp_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire mvp_pkg::in_item_t  s_item,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire mvp_pkg::out_item_t m_item
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.query_error |-> !m_item.partner_found)
        else $error("query error reported with a partner");

    a_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.partner_found |-> m_item.partner_index == '0)
        else $error("partner index nonzero without a partner");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.op == mvp_pkg::OP_QUERY |=> !s_ready)
        else $error("item accepted right after a query");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind mirror_vertex_pairing mvp_checker u_mvp_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_item (s_item),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_item (m_item)
);

`default_nettype wire

@@ bench/mirror_vertex_pairing_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for mirror_vertex_pairing: directed table, then random store/query phases.
module mirror_vertex_pairing_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int     LIMIT_CYCLES  = 600000;
    localparam int     SETTLE_CYCLES = 20;
    localparam int     DRAIN_CYCLES  = 64;
    localparam int     LONG_HOLD     = 400;
    localparam int     RANDOM_ITEMS  = 540;
    localparam int     QUIET_TAIL    = 80;
    localparam int     LONG_APPENDS  = 150;
    localparam longint C_MAX         = 64'sd8388607;
    localparam longint C_MIN         = -64'sd8388608;
    localparam logic [mvp_pkg::TOL_W-1:0] TOL_MAX = {mvp_pkg::TOL_W{1'b1}};

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e                     kind;
        mvp_pkg::in_item_t             item;
        logic [mvp_pkg::TOL_W-1:0]     tol;
        logic                          typed;
        mvp_pkg::out_item_t            want;
    } dir_row_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_valid   = 1'b0;
    mvp_pkg::in_item_t         s_item    = '0;
    logic                      m_ready   = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic [mvp_pkg::TOL_W-1:0] cfg_data  = '0;
    logic                      s_ready;
    logic                      m_valid;
    mvp_pkg::out_item_t        m_item;
    logic                      cfg_ready;

    // shadow of the block
    logic signed [mvp_pkg::POS_W-1:0] vtx_x [mvp_pkg::MAX_VERTICES];
    logic signed [mvp_pkg::POS_W-1:0] vtx_y [mvp_pkg::MAX_VERTICES];
    logic signed [mvp_pkg::POS_W-1:0] vtx_z [mvp_pkg::MAX_VERTICES];
    int                               vtx_count = 0;
    logic [mvp_pkg::TOL_W-1:0]        tol_reg   = mvp_pkg::TOL_RESET;

    mvp_pkg::out_item_t partner_due[$];
    dir_row_t           dir_rows[$];
    int                 errors    = 0;
    int                 cycles    = 0;
    bit                 gaps_on   = 1'b1;
    bit                 stall_on  = 1'b1;
    bit                 long_hold = 1'b0;

    mirror_vertex_pairing uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic signed [mvp_pkg::POS_W-1:0] sat_coord(input longint v);
        if (v > C_MAX) return mvp_pkg::POS_W'(C_MAX);
        if (v < C_MIN) return mvp_pkg::POS_W'(C_MIN);
        return mvp_pkg::POS_W'(v);
    endfunction

    function automatic mvp_pkg::in_item_t mk_item(input logic [1:0] op,
                                    input logic signed [mvp_pkg::POS_W-1:0] x, y, z,
                                    input logic [mvp_pkg::QIDX_W-1:0] qi);
        mvp_pkg::in_item_t it;
        it.op          = op;
        it.pos_x       = x;
        it.pos_y       = y;
        it.pos_z       = z;
        it.query_index = qi;
        return it;
    endfunction

    // closest vertex to the mirror image of vertex qi, strictly inside the radius
    function automatic mvp_pkg::out_item_t mirror_partner(
            input logic [mvp_pkg::QIDX_W-1:0] qi);
        mvp_pkg::out_item_t r;
        longint             mx, my, mz, ax, ay, az, d, best_d, tol;
        r = '0;
        if (qi >= vtx_count) begin
            r.query_error = 1'b1;
            return r;
        end
        tol    = longint'(tol_reg);
        best_d = tol * tol;
        mx     = -longint'(vtx_x[qi]);
        my     = longint'(vtx_y[qi]);
        mz     = longint'(vtx_z[qi]);
        for (int i = 0; i < vtx_count; i++) begin
            ax = mx - longint'(vtx_x[i]);
            ay = my - longint'(vtx_y[i]);
            az = mz - longint'(vtx_z[i]);
            if (ax < 0) ax = -ax;
            if (ay < 0) ay = -ay;
            if (az < 0) az = -az;
            if (ax >= tol || ay >= tol || az >= tol) continue;
            d = ax * ax + ay * ay + az * az;
            if (d < best_d) begin
                best_d          = d;
                r.partner_found = 1'b1;
                r.partner_index = mvp_pkg::QIDX_W'(i);
            end
        end
        return r;
    endfunction

    task automatic queue_result(input mvp_pkg::out_item_t w);
        partner_due = {partner_due, w};
    endtask

    task automatic apply_item(input mvp_pkg::in_item_t it);
        case (it.op)
            mvp_pkg::OP_CLEAR: vtx_count = 0;
            mvp_pkg::OP_APPEND: begin
                if (vtx_count < mvp_pkg::MAX_VERTICES) begin
                    vtx_x[vtx_count] = it.pos_x;
                    vtx_y[vtx_count] = it.pos_y;
                    vtx_z[vtx_count] = it.pos_z;
                    vtx_count++;
                end
            end
            mvp_pkg::OP_QUERY: queue_result(mirror_partner(it.query_index));
            default: ;
        endcase
    endtask

    task automatic report(input string what, input mvp_pkg::out_item_t got,
                          input mvp_pkg::out_item_t want);
        errors++;
        $display("[%0t] %s: got found=%0b idx=%0d err=%0b, want found=%0b idx=%0d err=%0b",
                 $time, what, got.partner_found, got.partner_index, got.query_error,
                 want.partner_found, want.partner_index, want.query_error);
    endtask

    task automatic send_item(input mvp_pkg::in_item_t it, input bit typed,
                             input mvp_pkg::out_item_t want);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (typed) queue_result(want);
        else apply_item(it);
    endtask

    task automatic settle(input int n);
        s_valid <= 1'b0;
        while (partner_due.size() != 0) @(posedge aclk);
        repeat (n) @(posedge aclk);
    endtask

    task automatic write_tolerance(input logic [mvp_pkg::TOL_W-1:0] t);
        settle(SETTLE_CYCLES);
        cfg_data  <= t;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        tol_reg = t;
    endtask

    function automatic int jitter(input int span);
        if (span <= 0) return 0;
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic longint rand_coord();
        logic signed [mvp_pkg::POS_W-1:0] c;
        c = mvp_pkg::POS_W'($urandom);
        case ($urandom_range(0, 9))
            0: return longint'(c);
            1: begin
                case ($urandom_range(0, 3))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return longint'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    // fresh vertex, near-mirror of a stored one, on- or near-plane one, or exact duplicate
    task automatic append_vertex();
        int     k;
        int     span;
        int     pick;
        longint x, y, z;
        pick = $urandom_range(0, 9);
        span = (tol_reg == 0) ? 2 : ((tol_reg > 200000) ? 200000 : int'(tol_reg));
        if ($urandom_range(0, 3) == 0) span = span * 2;
        else span = span / 2;
        if (vtx_count == 0 || pick < 4) begin
            x = rand_coord();
            y = rand_coord();
            z = rand_coord();
        end else begin
            k = $urandom_range(0, vtx_count - 1);
            x = vtx_x[k];
            y = vtx_y[k];
            z = vtx_z[k];
            if (pick < 8) begin
                x = -x + jitter(span);
                y = y + jitter(span);
                z = z + jitter(span);
            end else if (pick == 8) begin
                x = ($urandom_range(0, 1) == 0) ? 0 : jitter(span);
            end
        end
        send_item(mk_item(mvp_pkg::OP_APPEND, sat_coord(x), sat_coord(y), sat_coord(z),
                          mvp_pkg::QIDX_W'($urandom)), 1'b0, '0);
    endtask

    task automatic query_vertex(input int qi);
        send_item(mk_item(mvp_pkg::OP_QUERY, mvp_pkg::POS_W'($urandom),
                          mvp_pkg::POS_W'($urandom), mvp_pkg::POS_W'($urandom),
                          mvp_pkg::QIDX_W'(qi)), 1'b0, '0);
    endtask

    function automatic int pick_query();
        if (vtx_count > 0 && $urandom_range(0, 6) != 0)
            return $urandom_range(0, vtx_count - 1);
        return $urandom_range(0, 1023);
    endfunction

    function automatic logic [mvp_pkg::TOL_W-1:0] pick_tolerance(input int phase_no);
        case ((phase_no < 3) ? phase_no : $urandom_range(3, 9))
            0: return '0;
            1: return TOL_MAX;
            2: return mvp_pkg::TOL_W'(1);
            3: return mvp_pkg::TOL_RESET;
            4, 5: return mvp_pkg::TOL_W'($urandom_range(2, 4096));
            6: return mvp_pkg::TOL_W'($urandom_range(4097, 1 << 20));
            7: return mvp_pkg::TOL_W'($urandom);
            default: return mvp_pkg::TOL_W'($urandom_range(16, 1024));
        endcase
    endfunction

    function automatic dir_row_t item_row(input logic [1:0] op, input longint x, y, z,
                                          input int qi);
        dir_row_t r;
        r.kind  = ROW_ITEM;
        r.item  = mk_item(op, sat_coord(x), sat_coord(y), sat_coord(z),
                          mvp_pkg::QIDX_W'(qi));
        r.tol   = '0;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic dir_row_t typed_row(input int qi, input logic found, input int pidx,
                                           input logic err);
        dir_row_t r;
        r                    = item_row(mvp_pkg::OP_QUERY, 0, 0, 0, qi);
        r.typed              = 1'b1;
        r.want.partner_found = found;
        r.want.partner_index = mvp_pkg::QIDX_W'(pidx);
        r.want.query_error   = err;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [mvp_pkg::TOL_W-1:0] t);
        dir_row_t r;
        r      = item_row(mvp_pkg::OP_CLEAR, 0, 0, 0, 0);
        r.kind = ROW_CFG;
        r.tol  = t;
        return r;
    endfunction

    task automatic add_row(input dir_row_t r);
        dir_rows = {dir_rows, r};
    endtask

    // receiver: short random stalls, one long hold-off on request
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold = 1'b0;
            end else if (stall_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        mvp_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (partner_due.size() == 0) begin
                report("unexpected result", m_item, '0);
            end else begin
                want = partner_due.pop_front();
                if (m_item.partner_found !== want.partner_found)
                    report("partner_found", m_item, want);
                if (m_item.partner_index !== want.partner_index)
                    report("partner_index", m_item, want);
                if (m_item.query_error !== want.query_error)
                    report("query_error", m_item, want);
            end
        end
    end

    initial begin
        int phase_no;
        int rand_items;
        int n;
        int q;
        int r;
        phase_no   = 0;
        rand_items = 0;

        add_row(typed_row(0, 1'b0, 0, 1'b1));          // empty store
        add_row(item_row(OP_UNUSED, -5, 77, C_MAX, 1023));
        add_row(item_row(mvp_pkg::OP_APPEND, 0, 0, 0, 0));
        add_row(typed_row(0, 1'b1, 0, 1'b0));          // on plane, pairs with itself
        add_row(item_row(mvp_pkg::OP_APPEND, 256, 5, 5, 0));
        add_row(item_row(mvp_pkg::OP_APPEND, -256, 5, 5, 0));
        add_row(item_row(mvp_pkg::OP_QUERY, 0, 0, 0, 1));
        add_row(item_row(mvp_pkg::OP_APPEND, C_MIN, C_MAX, C_MIN, 0));
        add_row(item_row(mvp_pkg::OP_APPEND, C_MAX, C_MIN, C_MAX, 0));
        add_row(item_row(mvp_pkg::OP_QUERY, 0, 0, 0, 3));
        add_row(item_row(mvp_pkg::OP_QUERY, 0, 0, 0, 4));
        add_row(item_row(mvp_pkg::OP_APPEND, 100, 200, 300, 0));
        add_row(item_row(mvp_pkg::OP_APPEND, 100, 200, 300, 0));
        add_row(item_row(mvp_pkg::OP_APPEND, -100, 200, 300, 0));
        add_row(item_row(mvp_pkg::OP_QUERY, 0, 0, 0, 7));       // tie, lower index
        add_row(typed_row(8, 1'b0, 0, 1'b1));          // index == count
        add_row(typed_row(1023, 1'b0, 0, 1'b1));
        add_row(cfg_row('0));
        add_row(typed_row(0, 1'b0, 0, 1'b0));          // zero radius
        add_row(cfg_row(TOL_MAX));
        add_row(item_row(mvp_pkg::OP_QUERY, 0, 0, 0, 3));
        add_row(cfg_row(mvp_pkg::TOL_RESET));
        add_row(item_row(mvp_pkg::OP_CLEAR, 0, 0, 0, 0));
        add_row(item_row(mvp_pkg::OP_APPEND, 128, 0, 0, 0));
        add_row(item_row(mvp_pkg::OP_QUERY, 0, 0, 0, 0));       // exactly on radius
        add_row(item_row(mvp_pkg::OP_APPEND, -127, 0, 0, 0));
        add_row(item_row(mvp_pkg::OP_QUERY, 0, 0, 0, 0));
        add_row(item_row(mvp_pkg::OP_CLEAR, 0, 0, 0, 0));
        add_row(typed_row(0, 1'b0, 0, 1'b1));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) write_tolerance(dir_rows[i].tol);
            else send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end

        while (rand_items < RANDOM_ITEMS) begin
            write_tolerance(pick_tolerance(phase_no));
            gaps_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            if (rand_items >= RANDOM_ITEMS - QUIET_TAIL) begin
                gaps_on  = 1'b0;
                stall_on = 1'b0;
            end

            if (phase_no == 4) begin
                // long store, scanned end to end
                send_item(mk_item(mvp_pkg::OP_CLEAR, '0, '0, '0, '0), 1'b0, '0);
                for (int i = 0; i < LONG_APPENDS; i++) append_vertex();
                query_vertex(vtx_count - 1);
                query_vertex(0);
                repeat (3) query_vertex($urandom_range(0, 1023));
                rand_items += LONG_APPENDS + 6;
            end

            send_item(mk_item(mvp_pkg::OP_CLEAR, mvp_pkg::POS_W'($urandom),
                              mvp_pkg::POS_W'($urandom), mvp_pkg::POS_W'($urandom),
                              mvp_pkg::QIDX_W'($urandom)), 1'b0, '0);
            rand_items++;
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
            repeat (n) append_vertex();
            rand_items += n;

            if (phase_no == 2) begin
                gaps_on   = 1'b0;
                long_hold = 1'b1;
            end

            q = $urandom_range(3, 12);
            repeat (q) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    send_item(mk_item(OP_UNUSED, mvp_pkg::POS_W'($urandom),
                                      mvp_pkg::POS_W'($urandom), mvp_pkg::POS_W'($urandom),
                                      mvp_pkg::QIDX_W'($urandom)), 1'b0, '0);
                end else if (r == 1) begin
                    send_item(mk_item(mvp_pkg::OP_CLEAR, mvp_pkg::POS_W'($urandom),
                                      mvp_pkg::POS_W'($urandom), mvp_pkg::POS_W'($urandom),
                                      mvp_pkg::QIDX_W'($urandom)), 1'b0, '0);
                    rand_items++;
                end else if (r <= 4) begin
                    append_vertex();
                    rand_items++;
                end else begin
                    query_vertex(pick_query());
                    rand_items++;
                end
            end
            phase_no++;
        end

        gaps_on  = 1'b0;
        stall_on = 1'b0;
        settle(DRAIN_CYCLES);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
